// File: hdl/swrs_pkg.sv
// ----------------------------------------------------------------------------
// swrs_pkg: shared types and constants for the sliding window rank selector
// Sizes, the register map and the link record passed between window cells.
// ----------------------------------------------------------------------------
package swrs_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int AGE_W        = $clog2(MAX_WINDOW);
  localparam int LEN_W        = $clog2(MAX_WINDOW + 1);
  localparam int RANK_W       = 6;
  localparam int CFG_DATA_W   = 7;
  localparam int CFG_ADDR_W   = 2;
  localparam int USER_W       = 2;

  // tuser bit positions on the input side
  localparam int TUSER_EMIT    = 0;
  localparam int TUSER_RESTART = 1;

  // register defaults
  localparam int LEN_RESET  = 3;
  localparam int RANK_RESET = 1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [AGE_W-1:0]               age_t;
  typedef logic [LEN_W-1:0]               len_t;
  typedef logic [RANK_W-1:0]              rank_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WINDOW_LENGTH = CFG_ADDR_W'(0),
    REG_RANK_POSITION = CFG_ADDR_W'(1)
  } cfg_reg_t;

  // what a cell shows its neighbors: current entry, its age, and whether
  // the incoming sample sorts at or after it
  typedef struct packed {
    sample_t value;
    age_t    age;
    logic    ge;
  } cell_link_t;

endpackage

// File: hdl/swrs_cell.sv
// ----------------------------------------------------------------------------
// swrs_cell: one slot of the sorted window
// Holds one entry and its age; per word it drops the oldest entry and takes
// the new sample at its sorted place, shifting by one toward either side.
// ----------------------------------------------------------------------------
module swrs_cell (
  input  logic              clk,
  input  logic              clear,
  input  logic              step,
  input  logic              restart,
  input  logic              active,
  input  swrs_pkg::age_t    cell_idx,
  input  swrs_pkg::age_t    len_m1,
  input  swrs_pkg::sample_t sample_in,
  input  swrs_pkg::cell_link_t left_link,
  input  swrs_pkg::cell_link_t right_link,
  input  logic              left_taken,
  output swrs_pkg::cell_link_t link,
  output logic              taken,
  output logic              oldest,
  output swrs_pkg::sample_t value
);
  import swrs_pkg::*;

  age_t    age;
  sample_t cur_val;
  age_t    cur_age;
  logic    cur_ge;
  sample_t own_val, lft_val, value_next;
  age_t    own_age, lft_age, age_next;
  logic    own_ge, lft_ge;

  // restart sees a zeroed window with fresh ages
  always_comb begin
    cur_val = restart ? '0 : value;
    cur_age = restart ? cell_idx : age;
    cur_ge  = active & (sample_in >= cur_val);
    oldest  = active & (cur_age == len_m1);
    taken   = left_taken | oldest;
    link    = '{value: cur_val, age: cur_age, ge: cur_ge};
  end

  // after removal: entry landing here, and entry landing one to the left
  always_comb begin
    if (taken) begin
      own_val = right_link.value;
      own_age = right_link.age;
      own_ge  = right_link.ge;
    end else begin
      own_val = cur_val;
      own_age = cur_age;
      own_ge  = cur_ge;
    end
    if (left_taken) begin
      lft_val = cur_val;
      lft_age = cur_age;
      lft_ge  = cur_ge;
    end else begin
      lft_val = left_link.value;
      lft_age = left_link.age;
      lft_ge  = left_link.ge;
    end
  end

  // insert: stay below the new sample, take it, or shift up by one
  always_comb begin
    if (own_ge) begin
      value_next = own_val;
      age_next   = own_age + age_t'(1);
    end else if (lft_ge) begin
      value_next = sample_in;
      age_next   = '0;
    end else begin
      value_next = lft_val;
      age_next   = lft_age + age_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      value <= '0;
      age   <= cell_idx;
    end else if (step && active) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

// File: hdl/swrs_chain.sv
// ----------------------------------------------------------------------------
// swrs_chain: row of window cells
// Wires each cell to its neighbors and ripples the removed-slot flag along
// the row; the first len cells form the sorted window.
// ----------------------------------------------------------------------------
module swrs_chain (
  input  logic              clk,
  input  logic              clear,
  input  logic              step,
  input  logic              restart,
  input  swrs_pkg::len_t    len,
  input  swrs_pkg::sample_t sample_in,
  output swrs_pkg::sample_t values [swrs_pkg::MAX_WINDOW]
);
  import swrs_pkg::*;

  cell_link_t              links  [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]   taken;
  logic [MAX_WINDOW-1:0]   oldest;
  logic [MAX_WINDOW-1:0]   active;
  age_t                    len_m1;

  // boundary links: left of cell 0 always sorts below, right of the end above
  localparam cell_link_t LEFT_EDGE  = '{value: '0, age: '0, ge: 1'b1};
  localparam cell_link_t RIGHT_EDGE = '{value: '0, age: '0, ge: 1'b0};

  assign len_m1 = AGE_W'(len - len_t'(1));

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    assign active[i] = (len_t'(i) < len);

    swrs_cell u_cell (
      .clk        (clk),
      .clear      (clear),
      .step       (step),
      .restart    (restart),
      .active     (active[i]),
      .cell_idx   (age_t'(i)),
      .len_m1     (len_m1),
      .sample_in  (sample_in),
      .left_link  ((i == 0) ? LEFT_EDGE : links[(i == 0) ? 0 : i - 1]),
      .right_link ((i == MAX_WINDOW - 1) ? RIGHT_EDGE
                                         : links[(i == MAX_WINDOW - 1) ? i : i + 1]),
      .left_taken ((i == 0) ? 1'b0 : taken[(i == 0) ? 0 : i - 1]),
      .link       (links[i]),
      .taken      (taken[i]),
      .oldest     (oldest[i]),
      .value      (values[i])
    );
  end

`ifndef SYNTH
  // exactly one entry leaves the window on every word
  a_one_oldest: assert property (@(posedge clk) disable iff (clear)
    step |-> $onehot(oldest))
    else $error("swrs_chain: not exactly one oldest entry");

  // the active part of the row stays in ascending order
  for (genvar k = 0; k < MAX_WINDOW - 1; k++) begin : g_sorted
    a_sorted: assert property (@(posedge clk) disable iff (clear)
      active[k+1] |-> (values[k] <= values[k+1]))
      else $error("swrs_chain: window out of order at cell %0d", k);
  end
`endif

endmodule

// File: hdl/sliding_window_rank_selector.sv
// An emitting word updates the row and sets pend, then its rank value is registered.
// Throughput: one sample per clock while no read waits on a full output; the cycle is
// set by the cell row: each cell compares with the new sample, the removed-slot flag
// ripples along the row. Reset: rst (synchronous) zeroes the window, sets
// window_length 3 and rank 1, and empties the output stage; a window_length write
// also zeroes the window.
// sliding_window_rank_selector: running rank-order filter
// Sorted window kept in a row of cells; the configured rank is read out from
// the row after each emitting insert into a registered output stage.
// ----------------------------------------------------------------------------
module sliding_window_rank_selector (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [swrs_pkg::SAMPLE_WIDTH-1:0] s_tdata,   // [15:0] sample
  input  logic [swrs_pkg::USER_W-1:0]       s_tuser,   // [0] emit, [1] restart
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [swrs_pkg::SAMPLE_WIDTH-1:0] m_tdata,   // [15:0] rank_value
  // configuration writes
  input  logic                              cfg_we,
  input  logic [swrs_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [swrs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import swrs_pkg::*;

  len_t    len;
  rank_t   rank;
  len_t    cfg_len;
  age_t    sel;
  logic    clear;
  logic    step;
  logic    out_free;
  logic    pend;
  sample_t values [MAX_WINDOW];

  // window length write: zero maps to one, oversize saturates
  always_comb begin
    if (cfg_data == '0) begin
      cfg_len = len_t'(1);
    end else if (cfg_data > CFG_DATA_W'(MAX_WINDOW)) begin
      cfg_len = len_t'(MAX_WINDOW);
    end else begin
      cfg_len = len_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= len_t'(LEN_RESET);
      rank <= rank_t'(RANK_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: len  <= cfg_len;
        REG_RANK_POSITION: rank <= cfg_data[RANK_W-1:0];
        default: ;
      endcase
    end
  end

  assign clear = rst | (cfg_we && (cfg_index == REG_WINDOW_LENGTH));

  // handshake: stall only when a read is pending and the output is full
  assign out_free = !m_tvalid | m_tready;
  assign s_tready = !pend | out_free;
  assign step     = s_tvalid & s_tready;

  swrs_chain u_chain (
    .clk       (clk),
    .clear     (clear),
    .step      (step),
    .restart   (s_tuser[TUSER_RESTART]),
    .len       (len),
    .sample_in (sample_t'(s_tdata)),
    .values    (values)
  );

  // rank clamped below the window length
  assign sel = (len_t'(rank) >= len) ? AGE_W'(len - len_t'(1)) : AGE_W'(rank);

  // pending read of the row after an emitting insert
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (step) begin
      pend <= s_tuser[TUSER_EMIT];
    end else if (out_free) begin
      pend <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (pend && out_free) begin
      m_tdata <= values[sel];
    end
  end

`ifndef SYNTH
  a_emit_pends: assert property (@(posedge clk) disable iff (rst)
    (step && s_tuser[TUSER_EMIT]) |=> pend)
    else $error("swrs: emitting word did not schedule a read");

  a_valid_from_pend: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(pend))
    else $error("swrs: output word without a pending read");

  a_no_step_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (pend && m_tvalid && !m_tready) |=> $stable(u_chain.values[0]) || $past(clear))
    else $error("swrs: window changed while a read was blocked");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: sliding window rank selector
// Sends signed sample words with emit/restart flags through the input stream.
// Each emitted rank value is predicted from a local copy of the window and
// compared in order. A directed table comes first, then random phases under
// several window/rank settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import swrs_pkg::*;

  // register indexes outside the map; writes there must be ignored
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = CFG_ADDR_W'(3);
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 80;

  // one row of the directed table: a register write or a sample word
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_ADDR_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    sample_t               smp;
    logic                  emit;
    logic                  restart;
    logic                  known;
    sample_t               result;
  } step_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [SAMPLE_WIDTH-1:0] s_tdata = '0;
  logic [USER_W-1:0]       s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [SAMPLE_WIDTH-1:0] m_tdata;
  logic                    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // typed expectation that travels with the word being offered
  logic    typed_known = 1'b0;
  sample_t typed_rank = '0;

  // local copy of the window and registers
  sample_t win_vals [MAX_WINDOW];
  int      next_slot;
  int      win_len;
  int      sel_rank;

  sample_t pending_ranks [$];
  step_t   plan [$];

  int  tx_idle_pct = 19;
  int  rx_idle_pct = 61;
  bit  hold_go = 1'b0;
  logic rx_hold = 1'b0;
  int  mismatches = 0;
  int  words_in = 0;
  int  ranks_checked = 0;
  int  reg_writes = 0;
  sample_t want;

  sliding_window_rank_selector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---- window predictor ----

  function automatic void clear_window();
    for (int i = 0; i < MAX_WINDOW; i++) win_vals[i] = '0;
    next_slot = 0;
  endfunction

  // value at the selected rank of the ascending sorted window
  function automatic sample_t rank_of_window();
    sample_t keys [MAX_WINDOW];
    sample_t k;
    int r;
    int j;
    r = (sel_rank >= win_len) ? win_len - 1 : sel_rank;
    for (int i = 0; i < win_len; i++) begin
      k = win_vals[i];
      j = i;
      while (j > 0 && keys[j-1] > k) begin
        keys[j] = keys[j-1];
        j--;
      end
      keys[j] = k;
    end
    return keys[r];
  endfunction

  // insert one sample over the oldest slot; returns the rank value
  function automatic sample_t absorb_sample(sample_t v, logic restart);
    if (restart) clear_window();
    if (next_slot >= win_len) next_slot = 0;
    win_vals[next_slot] = v;
    next_slot++;
    if (next_slot >= win_len) next_slot = 0;
    return rank_of_window();
  endfunction

  function automatic void apply_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_WINDOW_LENGTH: begin
        // zero reads as one, oversize saturates; always restarts the window
        win_len = (val == 0) ? 1 : (val > MAX_WINDOW) ? MAX_WINDOW : int'(val);
        clear_window();
      end
      REG_RANK_POSITION: sel_rank = int'(val[RANK_W-1:0]);
      default: ;
    endcase
  endfunction

  // ---- checking ----

  task automatic report_mismatch(string what, sample_t got, sample_t exp_val);
    mismatches++;
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, exp_val);
  endtask

  // output words are checked before the input word of the same edge is absorbed
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        ranks_checked++;
        if (pending_ranks.size() == 0) begin
          report_mismatch("unexpected rank_value", sample_t'(m_tdata), '0);
        end else begin
          want = pending_ranks.pop_front();
          if (sample_t'(m_tdata) !== want) report_mismatch("rank_value", sample_t'(m_tdata), want);
        end
      end
      if (s_tvalid && s_tready) begin
        words_in++;
        want = absorb_sample(sample_t'(s_tdata), s_tuser[TUSER_RESTART]);
        if (s_tuser[TUSER_EMIT]) pending_ranks.push_back(typed_known ? typed_rank : want);
      end
    end
  end

  // ---- receiver: random stalls, plus one long hold-off ----

  always @(posedge clk) begin
    m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---- sender helpers ----

  task automatic maybe_gap();
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_word(sample_t v, logic emit, logic restart, logic known, sample_t res);
    logic [USER_W-1:0] u;
    u = '0;
    u[TUSER_EMIT] = emit;
    u[TUSER_RESTART] = restart;
    s_tvalid <= 1'b1;
    s_tdata <= v;
    s_tuser <= u;
    typed_known <= known;
    typed_rank <= res;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // wait for every rank value, then let silent inserts finish; the first edge
  // makes sure the last accepted word has been queued by the checker
  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain_and_settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    apply_reg(idx, val);
    reg_writes++;
    cfg_we <= 1'b0;
  endtask

  // mostly full-range, with extremes and a narrow band that forces ties
  function automatic sample_t pick_sample();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return sample_t'(16'h7FFF);
      1: return sample_t'(16'h8000);
      2, 3: return sample_t'($urandom_range(0, 8)) - sample_t'(4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic void row_item(sample_t v, logic emit, logic restart, logic known,
                                   sample_t res);
    step_t row;
    row = '0;
    row.smp = v;
    row.emit = emit;
    row.restart = restart;
    row.known = known;
    row.result = res;
    plan.push_back(row);
  endfunction

  function automatic void row_cfg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    step_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = val;
    plan.push_back(row);
  endfunction

  // hard stop
  initial begin
    #400_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---- main sequence ----

  int ph_len  [PHASES] = '{64, 1, 7, 64, 2, 0, 9, 0};   // 0: random write
  int ph_rank [PHASES] = '{31, 5, 3, 63, 0, -1, 4, -1}; // -1: random write

  initial begin
    logic [CFG_DATA_W-1:0] len_w;
    logic [CFG_DATA_W-1:0] rank_w;

    win_len = LEN_RESET;
    sel_rank = RANK_RESET;
    clear_window();

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: window 3, rank 1 after reset
    row_item(16'sd5, 1, 0, 1, 16'sd0);
    row_item(-16'sd32768, 1, 0, 1, 16'sd0);
    row_item(16'sd32767, 1, 0, 1, 16'sd5);
    row_item(16'sd7, 0, 0, 0, 16'sd0);
    row_item(-16'sd1, 1, 1, 1, 16'sd0);              // restart then insert
    row_cfg(REG_RANK_POSITION, 7'd63);               // rank above window picks the max
    row_item(16'sd100, 1, 0, 1, 16'sd100);
    row_cfg(REG_RANK_POSITION, 7'd0);                // minimum, window kept
    row_item(-16'sd5, 1, 0, 1, -16'sd5);
    row_cfg(REG_WINDOW_LENGTH, 7'd0);                // zero length taken as one
    row_item(16'sd32767, 1, 0, 1, 16'sd32767);
    row_item(-16'sd32768, 1, 0, 1, -16'sd32768);
    row_cfg(REG_WINDOW_LENGTH, 7'd127);              // saturates to full window
    row_item(-16'sd3, 1, 0, 1, -16'sd3);
    row_cfg(REG_RANK_POSITION, 7'h7F);               // upper data bit dropped: rank 63
    row_item(16'sd1, 1, 0, 1, 16'sd1);
    row_cfg(REG_SPARE_A, 7'h55);                     // no register here
    row_item(16'sd2, 1, 0, 1, 16'sd2);
    row_cfg(REG_SPARE_B, 7'h2A);
    row_cfg(REG_RANK_POSITION, 7'h40);               // rank 0
    row_item(-16'sd32768, 1, 0, 1, -16'sd32768);
    row_cfg(REG_WINDOW_LENGTH, 7'd5);
    row_cfg(REG_RANK_POSITION, 7'd2);                // running median of five
    row_item(16'sd4, 1, 0, 0, 16'sd0);
    row_item(16'sd4, 1, 0, 0, 16'sd0);
    row_item(16'sd4, 1, 0, 0, 16'sd0);               // ties
    row_item(-16'sd9, 0, 0, 0, 16'sd0);
    row_item(-16'sd2, 1, 1, 0, 16'sd0);
    row_item(16'sd32767, 1, 0, 0, 16'sd0);
    row_item(-16'sd32768, 1, 0, 0, 16'sd0);
    row_item(16'sd0, 1, 0, 0, 16'sd0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        maybe_gap();
        send_word(plan[i].smp, plan[i].emit, plan[i].restart, plan[i].known, plan[i].result);
      end
    end

    // random phases, each under its own window/rank setting
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 3) begin
        tx_idle_pct = 61;
        rx_idle_pct = 19;
      end else if (ph == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      len_w = (ph_len[ph] == 0) ? CFG_DATA_W'($urandom_range(0, 127)) : CFG_DATA_W'(ph_len[ph]);
      rank_w = (ph_rank[ph] < 0) ? CFG_DATA_W'($urandom_range(0, 127))
                                 : CFG_DATA_W'(ph_rank[ph]);
      write_reg(REG_WINDOW_LENGTH, len_w);
      write_reg(REG_RANK_POSITION, rank_w);
      // receiver holds off while the sender keeps offering
      if (ph == 6) hold_go = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n == PHASE_WORDS / 2) begin
          // rank change in mid-stream keeps the window contents
          if (ph == 1 || ph == 5) write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
          write_reg(REG_RANK_POSITION, CFG_DATA_W'($urandom_range(0, 63)));
        end
        maybe_gap();
        send_word(pick_sample(), $urandom_range(0, 99) < 75, $urandom_range(0, 99) < 3,
                  1'b0, '0);
      end
    end

    drain_and_settle();
    repeat (8) @(posedge clk);

    $display("Covered %0d sample words and %0d rank values over %0d register writes,",
             words_in, ranks_checked, reg_writes);
    $display("window sizes 1 to %0d, clamped ranks, restarts and a long output stall.",
             MAX_WINDOW);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sliding_window_rank_selector.f
hdl/swrs_pkg.sv
hdl/swrs_cell.sv
hdl/swrs_chain.sv
hdl/sliding_window_rank_selector.sv
tb/testbench.sv
